### rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/sfsd_pkg.sv
// Types and constants shared by the frame sync decoder modules.
package sfsd_pkg;

    localparam int FRAME_BYTES   = 25;
    localparam int NUM_CHANNELS  = 16;
    localparam int CHAN_BITS     = 11;
    localparam int PAYLOAD_BYTES = 22;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
    localparam int FILL_W        = 5;
    localparam int CHAN_NUM_W    = 4;
    localparam int CNT_W         = 16;
    localparam int OUT_DATA_W    = 56;
    localparam int PADDR_W       = 3;

    // Flag byte bit masks
    localparam logic [7:0] LOST_BIT     = 8'h04;
    localparam logic [7:0] FAILSAFE_BIT = 8'h08;

    // Register indexes (word address bit)
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    localparam logic [7:0] START_MARKER_RST = 8'h0F;
    localparam logic [7:0] END_MARKER_RST   = 8'h00;

    localparam logic [CHAN_NUM_W-1:0] LAST_CHAN = CHAN_NUM_W'(NUM_CHANNELS - 1);

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
    } t_cfg;

    // One accepted frame, as queued between front and back
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic                 failsafe;
        logic                 lost;
        logic                 resynced;
        logic [CNT_W-1:0]     frames_seen;
        logic [CNT_W-1:0]     resync_total;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

### rtl/sfsd_front.sv
// Front end: byte window, marker check and frame/resync bookkeeping.
module sfsd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  sfsd_pkg::t_cfg i_cfg,
    input  logic           i_fifo_full,
    output logic           o_push,
    output sfsd_pkg::t_frame o_frame
);
    import sfsd_pkg::*;

    logic [7:0]        r_win [FRAME_BYTES];
    logic [FILL_W-1:0] r_fill;
    logic              r_ever;
    logic              r_drop;
    logic [CNT_W-1:0]  r_frames;
    logic [CNT_W-1:0]  r_resyncs;

    logic             accept;
    logic             full_now;
    logic             hit;
    logic             resync;
    logic [CNT_W-1:0] n_resyncs;

    // Hold input off while the queue has no room for a frame
    assign o_ready  = !i_fifo_full;
    assign accept   = i_valid && o_ready;
    assign full_now = (r_fill >= FILL_W'(FRAME_BYTES - 1));
    assign hit      = full_now && (r_win[1] == i_cfg.start_marker)
                      && (i_byte == i_cfg.end_marker);
    assign resync    = r_drop && r_ever;
    assign n_resyncs = resync ? r_resyncs + 1'b1 : r_resyncs;
    assign o_push    = accept && hit;

    // Build the frame from the window as it stands before this byte shifts in
    always_comb begin
        for (int m = 0; m < PAYLOAD_BYTES; m++) begin
            o_frame.payload[8*m +: 8] = r_win[m+2];
        end
        o_frame.failsafe     = (r_win[FRAME_BYTES-1] & FAILSAFE_BIT) != 8'h00;
        o_frame.lost         = (r_win[FRAME_BYTES-1] & LOST_BIT) != 8'h00;
        o_frame.resynced     = resync;
        o_frame.frames_seen  = r_frames + 1'b1;
        o_frame.resync_total = n_resyncs;
    end

    // Shift each byte in at the top; the oldest byte falls out at index 0
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[FRAME_BYTES-1] <= i_byte;
        end
    end

    // Advance fill level and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_ever    <= 1'b0;
            r_drop    <= 1'b0;
            r_frames  <= '0;
            r_resyncs <= '0;
        end else if (accept) begin
            if (!full_now) begin
                r_fill <= r_fill + 1'b1;
            end else if (hit) begin
                r_fill    <= '0;
                r_frames  <= r_frames + 1'b1;
                r_resyncs <= n_resyncs;
                r_ever    <= 1'b1;
                r_drop    <= 1'b0;
            end else begin
                r_fill <= FILL_W'(FRAME_BYTES - 1);
                r_drop <= 1'b1;
            end
        end
    end

endmodule

### rtl/sfsd_frame_fifo.sv
// Two-entry frame queue between front and back.
module sfsd_frame_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sfsd_pkg::t_frame     i_frame,
    input  logic                 i_pop,
    output sfsd_pkg::t_frame     o_head,
    output sfsd_pkg::t_fifo_stat o_stat
);
    import sfsd_pkg::*;

    t_frame     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_head       = r_mem[r_rptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    // Store incoming frame
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_frame;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/sfsd_back.sv
// Back end: walks the channels of the head frame into the output register.
module sfsd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfsd_pkg::t_frame      i_head,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [sfsd_pkg::OUT_DATA_W-1:0] o_data,
    output logic                  o_last
);
    import sfsd_pkg::*;

    logic [CHAN_NUM_W-1:0] r_chan;
    logic                  r_valid;
    logic [CHAN_NUM_W-1:0] r_num;
    logic [CHAN_BITS-1:0]  r_value;
    logic                  r_fs;
    logic                  r_lost;
    logic                  r_resync;
    logic [CNT_W-1:0]      r_frames;
    logic [CNT_W-1:0]      r_resyncs;
    logic                  r_last;

    logic load;
    logic take;
    logic chan_last;

    assign load      = !r_valid || i_ready;
    assign take      = load && !i_empty;
    assign chan_last = (r_chan == LAST_CHAN);
    assign o_pop     = take && chan_last;

    // Fill output payload with the next channel of the head frame
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_num     <= r_chan;
            r_value   <= i_head.payload[CHAN_BITS*r_chan +: CHAN_BITS];
            r_fs      <= i_head.failsafe;
            r_lost    <= i_head.lost;
            r_resync  <= i_head.resynced;
            r_frames  <= i_head.frames_seen;
            r_resyncs <= i_head.resync_total;
            r_last    <= chan_last;
        end
    end

    // Advance channel index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan  <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (take) begin
                r_chan <= chan_last ? '0 : r_chan + 1'b1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_data  = {6'd0, r_resyncs, r_frames, r_resync, r_lost, r_fs, r_value, r_num};

endmodule

### rtl/sbus_frame_sync_decoder_top.sv
// Top level of the frame sync decoder: register port, front, queue, back.
//
//  channel   direction  beat content
//  s         in         one received byte
//  m         out        one decoded channel, tlast on the final channel of a frame
//  apb       in/out     start_marker at 0x0, end_marker at 0x4
//
// A byte is taken every cycle while the frame queue has room; a byte that
// completes a matching frame queues it in the same cycle. The back end issues
// one channel per cycle while the output is ready, so a frame drains while the
// next one gathers. Input stalls only when two frames wait in the queue.
// Reset is synchronous, active low, and clears window fill and counters.
module sbus_frame_sync_decoder_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [7:0] rx_byte
    input  logic [7:0]                     i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [3:0] channel_number, [14:4] channel_value, [15] failsafe_flag,
    // [16] lost_flag, [17] resynced, [33:18] frames_seen,
    // [49:34] resync_total, [55:50] zero
    output logic [sfsd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [sfsd_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [31:0]                    i_pwdata,
    output logic [31:0]                    o_prdata,
    output logic                           o_pready
);
    import sfsd_pkg::*;

    `include "assert_macros.svh"

    t_cfg       r_cfg;
    t_frame     push_frame;
    t_frame     head_frame;
    t_fifo_stat fifo_stat;
    logic       push;
    logic       pop;
    logic       cfg_wr;

    // Register port
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= START_MARKER_RST;
            r_cfg.end_marker   <= END_MARKER_RST;
        end else if (cfg_wr) begin
            case (i_paddr[2])
                REG_START_MARKER: r_cfg.start_marker <= i_pwdata[7:0];
                REG_END_MARKER:   r_cfg.end_marker   <= i_pwdata[7:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[2])
            REG_START_MARKER: o_prdata = {24'd0, r_cfg.start_marker};
            REG_END_MARKER:   o_prdata = {24'd0, r_cfg.end_marker};
            default:          o_prdata = 32'd0;
        endcase
    end

    sfsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_byte      (i_s_tdata),
        .i_cfg       (r_cfg),
        .i_fifo_full (fifo_stat.full),
        .o_push      (push),
        .o_frame     (push_frame)
    );

    sfsd_frame_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .i_pop   (pop),
        .o_head  (head_frame),
        .o_stat  (fifo_stat)
    );

    sfsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_frame),
        .i_empty (fifo_stat.empty),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

    // A frame is queued only when the queue has room for it
    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, push, !fifo_stat.full)
    // The final channel of a frame carries the highest channel number
    `ASSERT_IMPL(a_last_is_top, i_clk, i_rst_n, o_m_tvalid && o_m_tlast,
                 o_m_tdata[CHAN_NUM_W-1:0] == LAST_CHAN)
    // A new output beat is sourced from a queued frame
    `ASSERT_IMPL(a_valid_has_src, i_clk, i_rst_n, $rose(o_m_tvalid), $past(!fifo_stat.empty))
    // Popping the last channel empties or advances the queue
    `ASSERT_NEXT(a_pop_on_last, i_clk, i_rst_n, pop && !push, !fifo_stat.full)

endmodule
